>>> src/mm_pkg.sv
// Shared constants, types and helpers for the matrix multiply block.
// Used by mm_store, mm_cell and matrix_multiply.
`default_nettype none

package mm_pkg;

    localparam int MAX_DIM      = 8;
    localparam int DIM_W        = 4;
    localparam int IDX_W        = 3;
    localparam int ADDR_W       = 6;
    localparam int CNT_W        = 7;
    localparam int ELEM_W       = 16;
    localparam int PROD_W       = 32;
    localparam int SUM_W        = 35;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 48;
    localparam int DRAIN_CYCLES = MAX_DIM + 4;
    localparam int DRAIN_W      = 4;

    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_LEN = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic [IDX_W-1:0]         tag;
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
    } mm_tok_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/matrix_multiply.sv
// Top level of the matrix multiply block: load control, operand sequencer,
// chain of accumulator cells and result stream. Depends on mm_pkg, mm_store, mm_cell.
//
// The block takes one element per cycle, A then B in row-major order, into
// two 64-entry stores. After the last B element it stops taking items and
// computes the product one result row at a time: the sequencer reads one
// A/B pair per cycle from the stores and sends it down a chain of eight cells,
// each summing one result column. A row is issued as K*N pairs, then the chain
// is left to settle, then its N output items are sent; the single read port of
// each store sets the issue rate. Output items come in row-major order; tlast
// marks the last one. Shape registers are clamped to 1..8.
`default_nettype none

module matrix_multiply (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [1:0]                         cfg_index,
    input  wire logic [mm_pkg::DIM_W-1:0]           cfg_wr_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // elem_value[15:0]
    input  wire logic [mm_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // out_row[2:0], out_col[5:3], dot_sum[40:6], zero pad[47:41]
    output logic [mm_pkg::OUT_TDATA_W-1:0]          m_tdata,
    output logic                                    m_tlast
);
    import mm_pkg::*;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;

    logic [2:0]        state_reg, state_next;
    logic [DIM_W-1:0]  rows_reg, inner_reg, cols_reg;
    logic [CNT_W-1:0]  load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [IDX_W-1:0]  t_reg, t_next;
    logic [IDX_W-1:0]  emit_col_reg, emit_col_next;
    logic [ADDR_W-1:0] b_addr_reg, b_addr_next;
    logic [ADDR_W-1:0] a_base_reg, a_base_next;
    logic [DRAIN_W-1:0] wait_reg, wait_next;
    logic              iss_valid_reg;
    logic              iss_first_reg;
    logic [IDX_W-1:0]  iss_tag_reg;

    logic [DIM_W-1:0]  m_dim, k_dim, n_dim;
    logic [7:0]        size_a, total, idx_ext, b_off;
    logic              in_acc, out_acc, in_a, in_b, last_load;
    logic              col_last, t_last, row_last, emit_last;
    logic              unload, shift;
    logic [ADDR_W-1:0] wr_addr, a_rd;
    logic signed [ELEM_W-1:0] rd_a, rd_b;

    mm_tok_t                 tok [MAX_DIM+1];
    logic signed [SUM_W-1:0] sums [MAX_DIM+1];

    assign m_dim = clamp_dim(rows_reg);
    assign k_dim = clamp_dim(inner_reg);
    assign n_dim = clamp_dim(cols_reg);

    assign size_a    = 8'(m_dim) * 8'(k_dim);
    assign total     = size_a + 8'(k_dim) * 8'(n_dim);
    assign idx_ext   = {1'b0, load_cnt_reg};
    assign b_off     = idx_ext - size_a;
    assign in_a      = idx_ext < size_a;
    assign in_b      = !in_a && (idx_ext < total);
    assign last_load = (idx_ext + 8'd1) >= total;
    assign wr_addr   = in_a ? load_cnt_reg[ADDR_W-1:0] : b_off[ADDR_W-1:0];

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;

    assign col_last  = ({1'b0, col_reg} == n_dim - DIM_W'(1));
    assign t_last    = ({1'b0, t_reg} == k_dim - DIM_W'(1));
    assign row_last  = ({1'b0, row_reg} == m_dim - DIM_W'(1));
    assign emit_last = ({1'b0, emit_col_reg} == n_dim - DIM_W'(1));
    assign a_rd      = a_base_reg + ADDR_W'(t_reg);

    assign unload = (state_reg == ST_WAIT) && (wait_reg == '0);
    assign shift  = out_acc;

    assign m_tdata = {{(OUT_TDATA_W - SUM_W - 2*IDX_W){1'b0}}, sums[0], emit_col_reg, row_reg};
    assign m_tlast = row_last && emit_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= DIM_W'(MAX_DIM);
            inner_reg <= DIM_W'(MAX_DIM);
            cols_reg  <= DIM_W'(MAX_DIM);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROWS_A:    rows_reg  <= cfg_wr_data;
                REG_INNER_LEN: inner_reg <= cfg_wr_data;
                REG_COLS_B:    cols_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        t_next        = t_reg;
        emit_col_next = emit_col_reg;
        b_addr_next   = b_addr_reg;
        a_base_next   = a_base_reg;
        wait_next     = wait_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    if (last_load) begin
                        load_cnt_next = '0;
                        state_next    = ST_ISSUE;
                        row_next      = '0;
                        col_next      = '0;
                        t_next        = '0;
                        b_addr_next   = '0;
                        a_base_next   = '0;
                    end else begin
                        load_cnt_next = load_cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_ISSUE: begin
                b_addr_next = b_addr_reg + ADDR_W'(1);
                if (col_last) begin
                    col_next = '0;
                    t_next   = t_reg + IDX_W'(1);
                    if (t_last) begin
                        t_next     = '0;
                        state_next = ST_WAIT;
                        wait_next  = DRAIN_W'(DRAIN_CYCLES);
                    end
                end else begin
                    col_next = col_reg + IDX_W'(1);
                end
            end
            ST_WAIT: begin
                if (wait_reg == '0) begin
                    state_next    = ST_EMIT;
                    emit_col_next = '0;
                end else begin
                    wait_next = wait_reg - DRAIN_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_acc) begin
                    emit_col_next = emit_col_reg + IDX_W'(1);
                    if (emit_last) begin
                        emit_col_next = '0;
                        if (row_last) begin
                            state_next = ST_LOAD;
                        end else begin
                            state_next  = ST_ISSUE;
                            row_next    = row_reg + IDX_W'(1);
                            a_base_next = a_base_reg + ADDR_W'(k_dim);
                            b_addr_next = '0;
                            col_next    = '0;
                            t_next      = '0;
                        end
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            load_cnt_reg  <= '0;
            iss_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            iss_valid_reg <= (state_reg == ST_ISSUE);
        end
    end

    always_ff @(posedge aclk) begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        t_reg         <= t_next;
        emit_col_reg  <= emit_col_next;
        b_addr_reg    <= b_addr_next;
        a_base_reg    <= a_base_next;
        wait_reg      <= wait_next;
        iss_first_reg <= (t_reg == '0);
        iss_tag_reg   <= col_reg;
    end

    mm_store u_store (
        .aclk      (aclk),
        .wr_en_a   (in_acc && in_a),
        .wr_en_b   (in_acc && in_b),
        .wr_addr   (wr_addr),
        .wr_data   (s_tdata[ELEM_W-1:0]),
        .rd_addr_a (a_rd),
        .rd_addr_b (b_addr_reg),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    assign tok[0].valid = iss_valid_reg;
    assign tok[0].first = iss_first_reg;
    assign tok[0].tag   = iss_tag_reg;
    assign tok[0].a     = rd_a;
    assign tok[0].b     = rd_b;
    assign sums[MAX_DIM] = '0;

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        mm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(g)),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1]),
            .unload   (unload),
            .shift    (shift),
            .sum_in   (sums[g+1]),
            .sum_out  (sums[g])
        );
    end

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output active together");

    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("no return to loading after last result");

    a_issue_src: assert property (@(posedge aclk) disable iff (!aresetn)
        iss_valid_reg |-> $past(state_reg == ST_ISSUE))
        else $error("operand item without issue");

    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && last_load) |=> (state_reg == ST_ISSUE && load_cnt_reg == '0))
        else $error("compute did not start after last element");
`endif

endmodule

`default_nettype wire

>>> src/mm_store.sv
// Element stores for matrices A and B, one write port and registered reads.
// Depends on mm_pkg.
`default_nettype none

module mm_store (
    input  wire logic                             aclk,
    input  wire logic                             wr_en_a,
    input  wire logic                             wr_en_b,
    input  wire logic [mm_pkg::ADDR_W-1:0]        wr_addr,
    input  wire logic signed [mm_pkg::ELEM_W-1:0] wr_data,
    input  wire logic [mm_pkg::ADDR_W-1:0]        rd_addr_a,
    input  wire logic [mm_pkg::ADDR_W-1:0]        rd_addr_b,
    output logic signed [mm_pkg::ELEM_W-1:0]      rd_data_a,
    output logic signed [mm_pkg::ELEM_W-1:0]      rd_data_b
);
    import mm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic signed [ELEM_W-1:0] mem_a [DEPTH];
    logic signed [ELEM_W-1:0] mem_b [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en_a) begin
            mem_a[wr_addr] <= wr_data;
        end
        rd_data_a <= mem_a[rd_addr_a];
    end

    always_ff @(posedge aclk) begin
        if (wr_en_b) begin
            mem_b[wr_addr] <= wr_data;
        end
        rd_data_b <= mem_b[rd_addr_b];
    end

endmodule

`default_nettype wire

>>> src/mm_cell.sv
// One accumulator cell of the product chain: passes operand items on, takes
// those tagged for its column, and shifts finished sums toward cell 0. Depends on mm_pkg.
`default_nettype none

module mm_cell (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [mm_pkg::IDX_W-1:0]        cell_idx,
    input  wire mm_pkg::mm_tok_t                 tok_in,
    output mm_pkg::mm_tok_t                      tok_out,
    input  wire logic                            unload,
    input  wire logic                            shift,
    input  wire logic signed [mm_pkg::SUM_W-1:0] sum_in,
    output logic signed [mm_pkg::SUM_W-1:0]      sum_out
);
    import mm_pkg::*;

    mm_tok_t                  tok_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     pv_reg;
    logic                     pf_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  out_reg;
    logic signed [SUM_W-1:0]  prod_ext;
    logic                     hit;

    assign hit      = tok_reg.valid && (tok_reg.tag == cell_idx);
    assign prod_ext = SUM_W'(prod_reg);
    assign tok_out  = tok_reg;
    assign sum_out  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
            pv_reg        <= 1'b0;
        end else begin
            tok_reg <= tok_in;
            pv_reg  <= hit;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= $signed(tok_reg.a) * $signed(tok_reg.b);
        pf_reg   <= tok_reg.first;
        if (pv_reg) begin
            acc_reg <= pf_reg ? prod_ext : acc_reg + prod_ext;
        end
        if (unload) begin
            out_reg <= acc_reg;
        end else if (shift) begin
            out_reg <= sum_in;
        end
    end

endmodule

`default_nettype wire

>>> dv/mm_checker.sv
// Checker for matrix_multiply: watches the register port and both streams,
// predicts every product item and compares it field by field.
// Depends on mm_pkg for widths and register indexes.

module mm_checker
    import mm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [DIM_W-1:0]       cfg_wr_data,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                   m_tlast,
    output int                          err_cnt,
    output int                          pending,
    output int                          results_seen
);

    typedef struct {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } mm_result_t;

    logic signed [ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0]         rows_cfg;
    logic [DIM_W-1:0]         inner_cfg;
    logic [DIM_W-1:0]         cols_cfg;
    int unsigned              elem_cnt;
    mm_result_t               product_q [$];

    initial begin
        err_cnt      = 0;
        pending      = 0;
        results_seen = 0;
    end

    function automatic int unsigned span(input logic [DIM_W-1:0] v);
        if (v == 0) begin
            return 1;
        end
        if (v > MAX_DIM) begin
            return MAX_DIM;
        end
        return v;
    endfunction

    // Store one element; on the last element of B, queue the whole product.
    task automatic take_element(input logic signed [ELEM_W-1:0] v);
        int unsigned m, k, n, a_sz, total;
        longint      acc;
        mm_result_t  r;
        m     = span(rows_cfg);
        k     = span(inner_cfg);
        n     = span(cols_cfg);
        a_sz  = m * k;
        total = a_sz + k * n;
        if (elem_cnt < a_sz) begin
            a_mem[elem_cnt] = v;
        end else if (elem_cnt < total) begin
            b_mem[elem_cnt - a_sz] = v;
        end
        if (elem_cnt + 1 < total) begin
            elem_cnt++;
            return;
        end
        elem_cnt = 0;
        for (int unsigned i = 0; i < m; i++) begin
            for (int unsigned j = 0; j < n; j++) begin
                acc = 0;
                for (int unsigned t = 0; t < k; t++) begin
                    acc += longint'(a_mem[i*k+t]) * longint'(b_mem[t*n+j]);
                end
                r.row  = i[IDX_W-1:0];
                r.col  = j[IDX_W-1:0];
                r.sum  = acc[SUM_W-1:0];
                r.last = (i == m - 1) && (j == n - 1);
                product_q.push_back(r);
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        mm_result_t              want;
        logic [IDX_W-1:0]        got_row;
        logic [IDX_W-1:0]        got_col;
        logic signed [SUM_W-1:0] got_sum;
        if (!aresetn) begin
            product_q.delete();
            elem_cnt  = 0;
            rows_cfg  = DIM_W'(MAX_DIM);
            inner_cfg = DIM_W'(MAX_DIM);
            cols_cfg  = DIM_W'(MAX_DIM);
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ROWS_A:    rows_cfg  = cfg_wr_data;
                    REG_INNER_LEN: inner_cfg = cfg_wr_data;
                    REG_COLS_B:    cols_cfg  = cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                got_row = m_tdata[IDX_W-1:0];
                got_col = m_tdata[2*IDX_W-1:IDX_W];
                got_sum = m_tdata[2*IDX_W+SUM_W-1:2*IDX_W];
                if (product_q.size() == 0) begin
                    $error("result item with no product pending: tdata %h", m_tdata);
                    err_cnt++;
                end else begin
                    want = product_q.pop_front();
                    if (got_row !== want.row) begin
                        $error("out_row expected %0d got %0d", want.row, got_row);
                        err_cnt++;
                    end
                    if (got_col !== want.col) begin
                        $error("out_col expected %0d got %0d", want.col, got_col);
                        err_cnt++;
                    end
                    if (got_sum !== want.sum) begin
                        $error("dot_sum expected %0d got %0d", want.sum, got_sum);
                        err_cnt++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("final_flag expected %0d got %0d", want.last, m_tlast);
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                take_element(s_tdata);
            end
        end
        pending = product_q.size();
    end

endmodule

>>> dv/tb_matrix_multiply.sv
// Testbench top for matrix_multiply: clock, reset, shape register writes,
// element stream and result back-pressure; mm_checker does the comparing.
// Depends on mm_pkg, matrix_multiply and mm_checker.

module tb_matrix_multiply;
    import mm_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES   = 2 * DRAIN_CYCLES + 8;
    localparam int PRESSURE_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int ITEM_TARGET     = 270;

    typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_MIN} fill_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [1:0]             cfg_index;
    logic [DIM_W-1:0]       cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    int err_cnt;
    int pending;
    int results_seen;
    int items_sent = 0;
    int matrices   = 0;
    int reg_writes = 0;
    bit hold_arm   = 1'b0;
    bit no_gaps    = 1'b0;

    logic [DIM_W-1:0] raw_dim [3];

    always #4 aclk = ~aclk;

    matrix_multiply u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    mm_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .err_cnt      (err_cnt),
        .pending      (pending),
        .results_seen (results_seen)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic int dim_of(input logic [DIM_W-1:0] v);
        return (v == 0) ? 1 : ((v > MAX_DIM) ? MAX_DIM : int'(v));
    endfunction

    function automatic logic [DIM_W-1:0] rand_dim();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return DIM_W'($urandom_range(9, 15));
        end
        if (r == 2) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'($urandom_range(1, 4));
    endfunction

    function automatic logic [ELEM_W-1:0] rand_elem(input fill_t mode);
        int r;
        if (mode == FILL_MIN) begin
            return 16'h8000;
        end
        if (mode == FILL_EXTREME) begin
            return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        end
        r = $urandom_range(0, 7);
        case (r)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return ELEM_W'($signed($urandom_range(0, 1024)) - 512);
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx != REG_UNUSED) begin
            raw_dim[idx] = val;
        end
        reg_writes++;
    endtask

    task automatic send_elem(input logic [ELEM_W-1:0] v);
        int gap;
        gap = no_gaps ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic send_matrix(input fill_t mode);
        int k, count;
        k     = dim_of(raw_dim[REG_INNER_LEN]);
        count = dim_of(raw_dim[REG_ROWS_A]) * k + k * dim_of(raw_dim[REG_COLS_B]);
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int e = 0; e < count; e++) begin
            send_elem(rand_elem(mode));
        end
        drop_valid();
        matrices++;
    endtask

    task automatic settle();
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_shape(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] k,
                             input logic [DIM_W-1:0] n);
        write_reg(REG_ROWS_A, m);
        write_reg(REG_INNER_LEN, k);
        write_reg(REG_COLS_B, n);
    endtask

    initial begin : result_sink
        int stall;
        int free_run;
        int hold;
        bit hold_done;
        stall     = 0;
        free_run  = 0;
        hold      = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_arm && !hold_done && m_tvalid) begin
                hold      = PRESSURE_CYCLES;
                hold_done = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (free_run > 0) begin
                free_run--;
                m_tready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                case ($urandom_range(0, 31))
                    0:             free_run = $urandom_range(20, 60);
                    1, 2, 3, 4, 5: stall = idle_len();
                    default: ;
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Timeout after %0d idle cycles, %0d products pending", quiet, pending);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin : stimulus
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        raw_dim[REG_ROWS_A]    = DIM_W'(MAX_DIM);
        raw_dim[REG_INNER_LEN] = DIM_W'(MAX_DIM);
        raw_dim[REG_COLS_B]    = DIM_W'(MAX_DIM);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // 1x1x1 products at the corners of the element range
        set_shape(4'd1, 4'd1, 4'd1);
        send_elem(16'h8000);
        send_elem(16'h8000);
        send_elem(16'h7fff);
        send_elem(16'h8000);
        send_elem(16'h7fff);
        send_elem(16'h7fff);
        drop_valid();
        matrices += 3;
        settle();

        // zero clamps to one; the unused index leaves the shape alone
        set_shape(4'd0, 4'd0, 4'd0);
        write_reg(REG_UNUSED, 4'd5);
        send_elem(16'h0001);
        send_elem(16'hffff);
        send_elem(16'h0000);
        send_elem(16'h1234);
        drop_valid();
        matrices += 2;
        settle();

        // values above the maximum clamp to eight
        set_shape(4'd15, 4'd1, 4'd9);
        send_matrix(FILL_RANDOM);
        settle();

        set_shape(4'd8, 4'd8, 4'd8);
        send_matrix(FILL_RANDOM);
        settle();

        // largest dot sums
        set_shape(4'd1, 4'd8, 4'd1);
        send_matrix(FILL_MIN);
        send_matrix(FILL_EXTREME);
        settle();

        // hold results back while the next matrix is offered
        set_shape(4'd8, 4'd2, 4'd8);
        hold_arm = 1'b1;
        send_matrix(FILL_RANDOM);
        send_matrix(FILL_RANDOM);
        settle();

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 3) != 0) write_reg(REG_ROWS_A, rand_dim());
            if ($urandom_range(0, 3) != 0) write_reg(REG_INNER_LEN, rand_dim());
            if ($urandom_range(0, 3) != 0) write_reg(REG_COLS_B, rand_dim());
            if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, rand_dim());
            repeat ($urandom_range(1, 3)) begin
                send_matrix(($urandom_range(0, 5) == 0) ? FILL_EXTREME : FILL_RANDOM);
            end
            settle();
        end

        $display("Sent %0d elements in %0d products with %0d shape register writes",
                 items_sent, matrices, reg_writes);
        $display("Checked %0d result items, shapes 1x1x1 to 8x8x8 with output back-pressure",
                 results_seen);
        if (err_cnt == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
